// ===== design/mtsl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtsl_pkg
// Shared constants for the sorted-list merge block: command codes and the
// element width.
// ----------------------------------------------------------------------------
package mtsl_pkg;

   localparam int DATA_W = 32;

   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_MERGE  = 2'd2;

endpackage

// ===== design/merge_two_sorted_lists.sv =====
// ----------------------------------------------------------------------------
// merge_two_sorted_lists
// Loads two ascending lists into two list stores and emits their merge.
// ----------------------------------------------------------------------------
// Each load item produces no result; a load into a full list is dropped. A
// merge item starts a run that emits one value per cycle while the result
// side takes them, count_a + count_b values in all, the last one marked; the
// heads of both lists are read from the two stores in the cycle the merge is
// accepted, and each cycle the store of the emitting side is read at its
// next entry, so the store read latency is hidden. The input is not ready
// again until the final value sits in the output register. On equal heads
// the element of list B goes first. A merge of two empty lists produces
// nothing. Stores are not cleared after reset.
module merge_two_sorted_lists #(
   parameter int LIST_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_command,
   input  logic [mtsl_pkg::DATA_W-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mtsl_pkg::DATA_W-1:0] rsp_merged_value,
   output logic                        rsp_last
);
   import mtsl_pkg::*;

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   logic              state_ff, state_in;
   logic [CW-1:0]     count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [CW-1:0]     ia_ff, ia_in, ib_ff, ib_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept, wr_a, wr_b;
   logic              emit, take_a, emit_last;
   logic [DATA_W-1:0] head_a, head_b;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign wr_a      = accept && (req_command == CMD_LOAD_A) && (count_a_ff < FULL);
   assign wr_b      = accept && (req_command == CMD_LOAD_B) && (count_b_ff < FULL);

   mtsl_ram #(.ADDR_W(AW)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (ia_in[AW-1:0]),
      .rd_data (head_a)
   );

   mtsl_ram #(.ADDR_W(AW)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (ib_in[AW-1:0]),
      .rd_data (head_b)
   );

   // During a merge, the store outputs hold the entries at the current pointers.
   assign take_a = (ia_ff < count_a_ff) &&
                   ((ib_ff == count_b_ff) || ($signed(head_a) < $signed(head_b)));
   assign emit   = (state_ff == ST_MERGE) && (!rsp_valid_ff || rsp_ready);
   assign emit_last = take_a ?
      ((CW'(ia_ff + 1'b1) == count_a_ff) && (ib_ff == count_b_ff)) :
      ((CW'(ib_ff + 1'b1) == count_b_ff) && (ia_ff == count_a_ff));

   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (wr_a) begin
               count_a_in = CW'(count_a_ff + 1'b1);
            end
            if (wr_b) begin
               count_b_in = CW'(count_b_ff + 1'b1);
            end
            if (accept && (req_command == CMD_MERGE) &&
                ((count_a_ff != '0) || (count_b_ff != '0))) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = take_a ? head_a : head_b;
               rsp_last_in  = emit_last;
               if (emit_last) begin
                  state_in   = ST_IDLE;
                  ia_in      = '0;
                  ib_in      = '0;
                  count_a_in = '0;
                  count_b_in = '0;
               end else if (take_a) begin
                  ia_in = CW'(ia_ff + 1'b1);
               end else begin
                  ib_in = CW'(ib_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTH
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (ia_ff <= count_a_ff) && (ib_ff <= count_b_ff))
      else $error("merge pointer ran past its list count");

   a_merge_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> ((ia_ff < count_a_ff) || (ib_ff < count_b_ff)))
      else $error("merge running with both lists exhausted");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last) |=> ((count_a_ff == '0) && (count_b_ff == '0) &&
                               (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff))
      else $error("final item did not close the merge");
`endif

endmodule

// ===== design/mtsl_ram.sv =====
// ----------------------------------------------------------------------------
// mtsl_ram
// Simple dual-port list store: one write port and one read port with a
// registered read, so read data appears in the cycle after the address.
// ----------------------------------------------------------------------------
module mtsl_ram #(
   parameter int ADDR_W = 5
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [mtsl_pkg::DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [mtsl_pkg::DATA_W-1:0] rd_data
);
   import mtsl_pkg::*;

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
